[src/cbz_pkg.sv]
// ----------------------------------------------------------------------------
// cbz_pkg: shared types and constants for the cubic Bezier segment evaluator
// Holds the lane pipeline control struct and the fixed curve constants.
// ----------------------------------------------------------------------------
package cbz_pkg;

   // one lane per evaluation point: t = k/N and t = (k+1)/N
   localparam int NUM_LANES = 2;

   // control points per curve: P0, C1, C2, P3
   localparam int NUM_CTRL = 4;

   // binomial coefficient of the two inner Bernstein terms
   localparam int BERN_MID = 3;

   typedef struct packed {
      logic advance;   // every lane stage moves one step
      logic load;      // a new item enters the first stage on advance
   } pipe_ctrl_type;

endpackage

[src/cbz_if.sv]
// ----------------------------------------------------------------------------
// cbz_if: request and response channels of the Bezier segment evaluator
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface cbz_req_if #(
   parameter int COORD_BITS = 16,
   parameter int SEG_BITS   = 10
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] p0_x;
   logic signed [COORD_BITS-1:0] p0_y;
   logic signed [COORD_BITS-1:0] c1_x;
   logic signed [COORD_BITS-1:0] c1_y;
   logic signed [COORD_BITS-1:0] c2_x;
   logic signed [COORD_BITS-1:0] c2_y;
   logic signed [COORD_BITS-1:0] p3_x;
   logic signed [COORD_BITS-1:0] p3_y;
   logic        [SEG_BITS-1:0]   segment;

   modport source (
      output valid, p0_x, p0_y, c1_x, c1_y, c2_x, c2_y, p3_x, p3_y, segment,
      input  ready
   );
   modport sink (
      input  valid, p0_x, p0_y, c1_x, c1_y, c2_x, c2_y, p3_x, p3_y, segment,
      output ready
   );
endinterface

interface cbz_rsp_if #(
   parameter int COORD_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] start_x;
   logic signed [COORD_BITS-1:0] start_y;
   logic signed [COORD_BITS-1:0] end_x;
   logic signed [COORD_BITS-1:0] end_y;

   modport source (
      output valid, start_x, start_y, end_x, end_y,
      input  ready
   );
   modport sink (
      input  valid, start_x, start_y, end_x, end_y,
      output ready
   );
endinterface

[src/cbz_lane.sv]
// ----------------------------------------------------------------------------
// cbz_lane: one Bernstein evaluation lane
// Squares, then cubic weights, then weight-by-coordinate products, then a
// rounded sum for x and y at one parameter value t/N.
// ----------------------------------------------------------------------------
module cbz_lane
   import cbz_pkg::*;
#(
   parameter int STEPS      = 1024,
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  pipe_ctrl_type                ctrl,
   input  logic [$clog2(STEPS):0]       t_in,
   input  logic signed [COORD_BITS-1:0] x_in [NUM_CTRL],
   input  logic signed [COORD_BITS-1:0] y_in [NUM_CTRL],
   output logic                         out_valid,
   output logic signed [COORD_BITS-1:0] out_x,
   output logic signed [COORD_BITS-1:0] out_y
);

   localparam int SB = $clog2(STEPS);     // the user must keep STEPS a power of two; not enforced
   localparam int TB = SB + 1;            // holds 0 .. STEPS
   localparam int SQ = 2 * SB + 1;        // holds 0 .. STEPS^2
   localparam int WW = 3 * SB + 1;        // holds 0 .. STEPS^3
   localparam int PW = WW + 1 + COORD_BITS;
   localparam int SW = PW + 2;
   localparam logic [SW-1:0] HALF_D = SW'(1) << (3 * SB - 1);

   // stage A: s, t and their squares
   logic                         va_ff;
   logic [TB-1:0]                s_ff, t_ff, s_in;
   logic [SQ-1:0]                s_sq_ff, t_sq_ff, s_sq_in, t_sq_in;
   logic [2*TB-1:0]              s_sq_full, t_sq_full;
   logic signed [COORD_BITS-1:0] xa_ff [NUM_CTRL];
   logic signed [COORD_BITS-1:0] ya_ff [NUM_CTRL];

   // stage B: Bernstein weights
   logic                         vb_ff;
   logic [WW-1:0]                w_ff [NUM_CTRL];
   logic [WW-1:0]                w_in [NUM_CTRL];
   logic [SQ+TB-1:0]             w0_full, w1_full, w2_full, w3_full;
   logic [SQ+TB+1:0]             w1_x3, w2_x3;
   logic signed [COORD_BITS-1:0] xb_ff [NUM_CTRL];
   logic signed [COORD_BITS-1:0] yb_ff [NUM_CTRL];

   // stage C: products
   logic                         vc_ff;
   logic signed [PW-1:0]         px_ff [NUM_CTRL];
   logic signed [PW-1:0]         py_ff [NUM_CTRL];
   logic signed [PW-1:0]         px_in [NUM_CTRL];
   logic signed [PW-1:0]         py_in [NUM_CTRL];

   logic signed [SW-1:0]         acc_x, acc_y;

   always_comb begin
      s_in      = TB'(STEPS) - t_in;
      s_sq_full = s_in * s_in;
      t_sq_full = t_in * t_in;
      s_sq_in   = s_sq_full[SQ-1:0];
      t_sq_in   = t_sq_full[SQ-1:0];
   end

   always_comb begin
      w0_full = s_sq_ff * s_ff;
      w1_full = s_sq_ff * t_ff;
      w2_full = t_sq_ff * s_ff;
      w3_full = t_sq_ff * t_ff;
      w1_x3   = (SQ+TB+2)'(w1_full) * (SQ+TB+2)'(BERN_MID);
      w2_x3   = (SQ+TB+2)'(w2_full) * (SQ+TB+2)'(BERN_MID);
      w_in[0] = w0_full[WW-1:0];
      w_in[1] = w1_x3[WW-1:0];
      w_in[2] = w2_x3[WW-1:0];
      w_in[3] = w3_full[WW-1:0];
   end

   always_comb begin
      for (int i = 0; i < NUM_CTRL; i++) begin
         px_in[i] = $signed({1'b0, w_ff[i]}) * xb_ff[i];
         py_in[i] = $signed({1'b0, w_ff[i]}) * yb_ff[i];
      end
   end

   // weights sum to STEPS^3: add half of it, then shift for floor
   always_comb begin
      acc_x = $signed(HALF_D);
      acc_y = $signed(HALF_D);
      for (int i = 0; i < NUM_CTRL; i++) begin
         acc_x = acc_x + SW'(px_ff[i]);
         acc_y = acc_y + SW'(py_ff[i]);
      end
   end

   assign out_valid = vc_ff;
   assign out_x     = acc_x[3*SB +: COORD_BITS];
   assign out_y     = acc_y[3*SB +: COORD_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else if (ctrl.advance) begin
         va_ff <= ctrl.load;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         s_ff    <= s_in;
         t_ff    <= t_in;
         s_sq_ff <= s_sq_in;
         t_sq_ff <= t_sq_in;
         xa_ff   <= x_in;
         ya_ff   <= y_in;
         w_ff    <= w_in;
         xb_ff   <= xa_ff;
         yb_ff   <= ya_ff;
         px_ff   <= px_in;
         py_ff   <= py_in;
      end
   end

endmodule

[src/cbz_merge.sv]
// ----------------------------------------------------------------------------
// cbz_merge: joins the two lane points into one segment and drives the
// response channel through an output register with a skid stage
// ----------------------------------------------------------------------------
module cbz_merge
   import cbz_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [NUM_LANES-1:0]         lane_valid,
   input  logic signed [COORD_BITS-1:0] start_x,
   input  logic signed [COORD_BITS-1:0] start_y,
   input  logic signed [COORD_BITS-1:0] end_x,
   input  logic signed [COORD_BITS-1:0] end_y,
   output logic                         in_ready,
   cbz_rsp_if.source                    rsp_bus
);

   localparam int PB = 4 * COORD_BITS;

   logic          out_valid_ff, skid_valid_ff;
   logic [PB-1:0] out_data_ff, skid_data_ff;
   logic [PB-1:0] in_data;
   logic          in_fire, out_fire;

   assign in_data  = {start_x, start_y, end_x, end_y};
   assign in_ready = !skid_valid_ff;
   assign in_fire  = (&lane_valid) && in_ready;
   assign out_fire = out_valid_ff && rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_fire) begin
         if (skid_valid_ff) begin
            out_data_ff   <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end else if (in_fire) begin
            out_data_ff <= in_data;
         end else begin
            out_valid_ff <= 1'b0;
         end
      end else if (!out_valid_ff) begin
         if (in_fire) begin
            out_data_ff  <= in_data;
            out_valid_ff <= 1'b1;
         end
      end else if (in_fire) begin
         // output is held: park the new segment
         skid_data_ff  <= in_data;
         skid_valid_ff <= 1'b1;
      end
   end

   assign rsp_bus.valid   = out_valid_ff;
   assign rsp_bus.start_x = out_data_ff[4*COORD_BITS-1 -: COORD_BITS];
   assign rsp_bus.start_y = out_data_ff[3*COORD_BITS-1 -: COORD_BITS];
   assign rsp_bus.end_x   = out_data_ff[2*COORD_BITS-1 -: COORD_BITS];
   assign rsp_bus.end_y   = out_data_ff[COORD_BITS-1 -: COORD_BITS];

endmodule

[src/cubic_bezier_segment_eval.sv]
// ----------------------------------------------------------------------------
// cubic_bezier_segment_eval: endpoints of one segment of a 2D cubic Bezier
// A request passes lane stages A, B, C and the merge output register in turn.
// Throughput: one segment per cycle when not stalled; two lanes evaluate
// t = k/N and t = (k+1)/N side by side in a 3-stage multiplier pipeline each.
// The pipeline stalls only when both output register and skid stage are full.
// Reset clears all valid state; no clearing pass is needed.
// STEPS must be a power of two.
// ----------------------------------------------------------------------------
module cubic_bezier_segment_eval
   import cbz_pkg::*;
#(
   parameter int STEPS      = 1024,
   parameter int COORD_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   cbz_req_if.sink   req_bus,
   cbz_rsp_if.source rsp_bus
);

   localparam int SB = $clog2(STEPS);
   localparam int TB = SB + 1;

   pipe_ctrl_type                ctrl;
   logic                         merge_ready;
   logic [NUM_LANES-1:0]         lane_valid;
   logic [TB-1:0]                t_start, t_end;
   logic signed [COORD_BITS-1:0] ctrl_x [NUM_CTRL];
   logic signed [COORD_BITS-1:0] ctrl_y [NUM_CTRL];
   logic signed [COORD_BITS-1:0] start_x, start_y, end_x, end_y;

   assign ctrl.advance  = merge_ready;
   assign ctrl.load     = req_bus.valid;
   assign req_bus.ready = merge_ready;

   // hold a segment past the last one at the last one
   always_comb begin
      if (32'(req_bus.segment) > 32'(STEPS - 1)) begin
         t_start = TB'(STEPS - 1);
      end else begin
         t_start = TB'(req_bus.segment);
      end
   end

   assign t_end = t_start + TB'(1);

   assign ctrl_x = '{req_bus.p0_x, req_bus.c1_x, req_bus.c2_x, req_bus.p3_x};
   assign ctrl_y = '{req_bus.p0_y, req_bus.c1_y, req_bus.c2_y, req_bus.p3_y};

   cbz_lane #(
      .STEPS      (STEPS),
      .COORD_BITS (COORD_BITS)
   ) u_lane_start (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .t_in      (t_start),
      .x_in      (ctrl_x),
      .y_in      (ctrl_y),
      .out_valid (lane_valid[0]),
      .out_x     (start_x),
      .out_y     (start_y)
   );

   cbz_lane #(
      .STEPS      (STEPS),
      .COORD_BITS (COORD_BITS)
   ) u_lane_end (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .t_in      (t_end),
      .x_in      (ctrl_x),
      .y_in      (ctrl_y),
      .out_valid (lane_valid[1]),
      .out_x     (end_x),
      .out_y     (end_y)
   );

   cbz_merge #(
      .COORD_BITS (COORD_BITS)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .lane_valid (lane_valid),
      .start_x    (start_x),
      .start_y    (start_y),
      .end_x      (end_x),
      .end_y      (end_y),
      .in_ready   (merge_ready),
      .rsp_bus    (rsp_bus)
   );

   // both lanes move in lockstep
   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      lane_valid[0] == lane_valid[1])
      else $error("lane valid bits diverged");

   // a stall upstream means a segment is already offered downstream
   a_stall_has_output: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> rsp_bus.valid)
      else $error("request stalled with no response offered");

   // a lane result that the merge cannot take must hold
   a_lane_holds: assert property (@(posedge clock) disable iff (reset)
      (lane_valid[0] && !merge_ready) |=>
         (lane_valid[0] && $stable(start_x) && $stable(end_y)))
      else $error("held lane result changed");

endmodule

[dv/cubic_bezier_segment_eval_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_bezier_segment_eval_test: self-checking bench for the segment evaluator
// Walks a table of directed curves (extremes, endpoint segments, rounding
// ties), then random curves, through the valid/ready channels under three
// idle patterns. Every response is compared field by field with an exact
// integer Bernstein evaluation or a typed-in answer, in request transfer order.
// ----------------------------------------------------------------------------
module cubic_bezier_segment_eval_test;
   import cbz_pkg::*;

   localparam int STEP_BITS   = 10;
   localparam int STEPS       = 1 << STEP_BITS;
   localparam int COORD_BITS  = 16;
   localparam int CUBE_SHIFT  = 3 * STEP_BITS;
   localparam longint HALF_CUBE = longint'(1) << (CUBE_SHIFT - 1);
   localparam int TOTAL_ITEMS = 1750;
   localparam int DIR_ROWS    = 20;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 24;
   localparam int REPORT_MAX  = 10;

   localparam logic signed [COORD_BITS-1:0] CMIN = 16'sh8000;
   localparam logic signed [COORD_BITS-1:0] CMAX = 16'sh7FFF;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type p0_x, p0_y, c1_x, c1_y, c2_x, c2_y, p3_x, p3_y;
      logic [STEP_BITS-1:0] segment;
   } seg_req_type;

   typedef struct packed {
      coord_type start_x, start_y, end_x, end_y;
   } seg_pts_type;

   typedef struct packed {
      seg_req_type req;
      logic        known;
      seg_pts_type pts;
   } seg_row_type;

   localparam seg_pts_type NO_PTS = '0;

   // curves whose answer is plain are typed in; the rest go to the predictor
   seg_row_type dir_rows [DIR_ROWS] = '{
      '{'{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 10'd0}, 1'b1,
        '{CMIN, CMIN, CMIN, CMIN}},
      '{'{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 10'd1023}, 1'b1,
        '{CMAX, CMAX, CMAX, CMAX}},
      '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 10'd512},
        1'b1, '{16'sd0, 16'sd0, 16'sd0, 16'sd0}},
      '{'{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, 10'd777}, 1'b1,
        '{CMAX, CMIN, CMAX, CMIN}},
      '{'{CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN, 10'd0}, 1'b0, NO_PTS},
      '{'{CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN, 10'd1}, 1'b0, NO_PTS},
      '{'{CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN, 10'd511}, 1'b0, NO_PTS},
      '{'{CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN, 10'd512}, 1'b0, NO_PTS},
      '{'{CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN, 10'd1022}, 1'b0, NO_PTS},
      '{'{CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN, 10'd1023}, 1'b0, NO_PTS},
      '{'{CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, 10'h155}, 1'b0, NO_PTS},
      '{'{CMAX, CMIN, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN, 10'h2AA}, 1'b0, NO_PTS},
      // exact halves at t = 1/2 round toward plus infinity
      '{'{16'sd4, -16'sd4, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 10'd512},
        1'b0, NO_PTS},
      '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd4, -16'sd4, 10'd511},
        1'b0, NO_PTS},
      '{'{16'sd0, 16'sd0, 16'sd4, -16'sd4, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 10'd512},
        1'b0, NO_PTS},
      '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd4, 16'sd4, 16'sd0, 16'sd0, 10'd511},
        1'b0, NO_PTS},
      '{'{16'sd1, -16'sd1, -16'sd1, 16'sd1, 16'sd1, -16'sd1, -16'sd1, 16'sd1, 10'd256},
        1'b0, NO_PTS},
      '{'{CMIN, 16'sd0, 16'sd0, CMAX, CMAX, 16'sd0, 16'sd0, CMIN, 10'd1}, 1'b0, NO_PTS},
      '{'{16'sh5555, 16'shAAAA, 16'shAAAA, 16'sh5555, 16'sh5555, 16'shAAAA,
          16'shAAAA, 16'sh5555, 10'h155}, 1'b0, NO_PTS},
      '{'{16'sh1234, -16'sh1234, 16'sh7000, -16'sh7000, -16'sh7000, 16'sh7000,
          16'sh4321, -16'sh4321, 10'd100}, 1'b0, NO_PTS}
   };

   logic clock;
   logic reset;

   cbz_req_if #(.COORD_BITS(COORD_BITS), .SEG_BITS(STEP_BITS)) req_bus ();
   cbz_rsp_if #(.COORD_BITS(COORD_BITS)) rsp_bus ();

   cubic_bezier_segment_eval #(
      .STEPS      (STEPS),
      .COORD_BITS (COORD_BITS)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   seg_pts_type pending_segments [$];
   int          mismatch_count = 0;
   int          cycle_count = 0;
   int          send_idle_pct = 8;
   int          recv_idle_pct = 73;

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // one coordinate of B(k/STEPS), exact weights, rounded half up
   function automatic coord_type curve_coord(longint k, coord_type q0, coord_type q1,
                                             coord_type q2, coord_type q3);
      longint s;
      longint acc;
      s = longint'(STEPS) - k;
      acc = s * s * s * longint'(q0)
          + longint'(BERN_MID) * s * s * k * longint'(q1)
          + longint'(BERN_MID) * s * k * k * longint'(q2)
          + k * k * k * longint'(q3);
      return coord_type'((acc + HALF_CUBE) >>> CUBE_SHIFT);
   endfunction

   function automatic seg_pts_type segment_points(seg_req_type r);
      seg_pts_type p;
      longint      k;
      k = longint'(r.segment);
      p.start_x = curve_coord(k, r.p0_x, r.c1_x, r.c2_x, r.p3_x);
      p.start_y = curve_coord(k, r.p0_y, r.c1_y, r.c2_y, r.p3_y);
      p.end_x   = curve_coord(k + 1, r.p0_x, r.c1_x, r.c2_x, r.p3_x);
      p.end_y   = curve_coord(k + 1, r.p0_y, r.c1_y, r.c2_y, r.p3_y);
      return p;
   endfunction

   function automatic coord_type random_coord();
      coord_type c;
      case ($urandom_range(9))
         0: c = CMIN;
         1: c = CMAX;
         2: begin
            c = coord_type'($urandom_range(16));
            c = c - 16'sd8;
         end
         default: c = coord_type'($urandom);
      endcase
      return c;
   endfunction

   function automatic seg_req_type random_segment_req();
      seg_req_type r;
      r.p0_x = random_coord();
      r.p0_y = random_coord();
      r.c1_x = random_coord();
      r.c1_y = random_coord();
      r.c2_x = random_coord();
      r.c2_y = random_coord();
      r.p3_x = random_coord();
      r.p3_y = random_coord();
      case ($urandom_range(15))
         0: r.segment = '0;
         1: r.segment = '1;
         default: r.segment = STEP_BITS'($urandom);
      endcase
      return r;
   endfunction

   // entered at a falling edge; returns at the falling edge after the transfer
   task automatic send_segment(seg_req_type r, seg_pts_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.p0_x    <= r.p0_x;
      req_bus.p0_y    <= r.p0_y;
      req_bus.c1_x    <= r.c1_x;
      req_bus.c1_y    <= r.c1_y;
      req_bus.c2_x    <= r.c2_x;
      req_bus.c2_y    <= r.c2_y;
      req_bus.p3_x    <= r.p3_x;
      req_bus.p3_y    <= r.p3_y;
      req_bus.segment <= r.segment;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_segments.push_back(want);
      @(negedge clock);
   endtask

   task automatic check_field(string name, coord_type want, coord_type got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_MAX)
            $display("%0d: %s mismatch: expected %0d, got %0d", cycle_count, name,
                     want, got);
      end
   endtask

   // stimulus
   initial begin
      seg_req_type r;
      seg_pts_type want;
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.p0_x    = '0;
      req_bus.p0_y    = '0;
      req_bus.c1_x    = '0;
      req_bus.c1_y    = '0;
      req_bus.c2_x    = '0;
      req_bus.c2_y    = '0;
      req_bus.p3_x    = '0;
      req_bus.p3_y    = '0;
      req_bus.segment = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < TOTAL_ITEMS; i++) begin
         case (i * 3 / TOTAL_ITEMS)
            0: begin
               send_idle_pct = 8;
               recv_idle_pct = 73;
            end
            1: begin
               send_idle_pct = 73;
               recv_idle_pct = 8;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         if (i < DIR_ROWS) begin
            r = dir_rows[i].req;
            want = dir_rows[i].known ? dir_rows[i].pts : segment_points(r);
         end else begin
            r = random_segment_req();
            want = segment_points(r);
         end
         send_segment(r, want);
      end
      req_bus.valid <= 1'b0;

      while (pending_segments.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // response backpressure
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // compare each response transfer with the oldest expected segment
   always @(posedge clock) begin
      seg_pts_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_segments.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("%0d: response with no request outstanding: %0d %0d %0d %0d",
                        cycle_count, rsp_bus.start_x, rsp_bus.start_y,
                        rsp_bus.end_x, rsp_bus.end_y);
         end else begin
            want = pending_segments.pop_front();
            check_field("start_x", want.start_x, rsp_bus.start_x);
            check_field("start_y", want.start_y, rsp_bus.start_y);
            check_field("end_x", want.end_x, rsp_bus.end_x);
            check_field("end_y", want.end_y, rsp_bus.end_y);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

endmodule
